/* rtl/nosc_pkg.sv */
// ----------------------------------------------------------------------------
// nosc_pkg
// Types, code points and helper functions shared by the natural-order string
// comparator and its channel interfaces.
// ----------------------------------------------------------------------------
package nosc_pkg;

  localparam int UnitW  = 16;
  localparam int OrderW = 2;

  // Verdict codes
  localparam logic [OrderW-1:0] ORDER_LESS    = 2'd0;
  localparam logic [OrderW-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [OrderW-1:0] ORDER_GREATER = 2'd2;

  // Character constants
  localparam logic [UnitW-1:0] DIGIT_ZERO  = 16'h0030;
  localparam logic [UnitW-1:0] DIGIT_NINE  = 16'h0039;
  localparam logic [UnitW-1:0] UPPER_A     = 16'h0041;
  localparam logic [UnitW-1:0] UPPER_Z     = 16'h005A;
  localparam logic [UnitW-1:0] CASE_OFFSET = 16'h0020;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // Walk phases
  typedef enum logic [2:0] {
    M_CHAR = 3'b001,
    M_SCAN = 3'b010,
    M_RUN  = 3'b100
  } mode_e;

  function automatic logic is_digit(input logic [UnitW-1:0] c);
    return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
  endfunction

  // ASCII upper case to lower case, everything else unchanged
  function automatic logic [UnitW-1:0] fold_case(input logic [UnitW-1:0] c);
    if ((c >= UPPER_A) && (c <= UPPER_Z)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

/* rtl/nosc_if.sv */
// ----------------------------------------------------------------------------
// nosc_if
// Valid/ready channels of the comparator: the character-pair request channel
// and the verdict channel.
// ----------------------------------------------------------------------------
interface nosc_in_if
  import nosc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] char_a;
  logic [UnitW-1:0] char_b;
  logic             last;

  modport source (output valid, output char_a, output char_b, output last, input ready);
  modport sink   (input valid, input char_a, input char_b, input last, output ready);
endinterface

interface nosc_out_if
  import nosc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OrderW-1:0] order;
  logic              truncated;

  modport source (output valid, output order, output truncated, input ready);
  modport sink   (input valid, input order, input truncated, output ready);
endinterface

/* rtl/nosc_ram.sv */
// ----------------------------------------------------------------------------
// nosc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nosc_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/natural_order_string_compare.sv */
// ----------------------------------------------------------------------------
// natural_order_string_compare
// Loads two strings one code-unit pair per request, then walks both buffers
// and returns one natural-order verdict with a truncation flag.
// ----------------------------------------------------------------------------
// Loading: one pair per cycle, ready whenever the sequencer is idle.
// Walk: each step reads both buffers, then evaluates the read units (ST_FETCH,
//   then ST_EVAL); the verdict passes through ST_DONE into the output register,
//   and waits in ST_DONE while a previous verdict is still held there.
// Reset: control state and the descending bit cleared; the buffers are left
//   undefined and are never read beyond the loaded length, so no clearing pass.
module natural_order_string_compare
  import nosc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  nosc_in_if.sink      in_i,
  nosc_out_if.source   out_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [CW-1:0]     load_count_q, load_count_d;
  logic              ovf_q, ovf_d;
  logic              desc_cfg_q;
  logic              desc_q, desc_d;
  logic [CW-1:0]     px_q, px_d, py_q, py_d, ex_q, ex_d, ey_q, ey_d;
  logic              xdone_q, xdone_d, ydone_q, ydone_d;
  logic              ok_x_q, ok_y_q;
  logic              out_valid_q, out_valid_d;
  logic [OrderW-1:0] verdict_q, verdict_d;
  logic              trunc_q, trunc_d;
  logic [OrderW-1:0] out_order_q, out_order_d;
  logic              out_trunc_q, out_trunc_d;

  logic              in_fire, buf_free, ovf_new;
  logic              we;
  logic [CW-1:0]     addr_x, addr_y, addr_a, addr_b;
  logic [UnitW-1:0]  rd_a, rd_b, dx, dy;
  logic [CW-1:0]     lx, ly;

  assign in_fire  = in_i.valid && in_i.ready;
  assign buf_free = load_count_q < CW'(MAX_LEN);
  assign in_i.ready = (state_q == ST_LOAD);

  assign out_o.valid     = out_valid_q;
  assign out_o.order     = out_order_q;
  assign out_o.truncated = out_trunc_q;

  // Read addresses: scan phase looks ahead at run ends, else at the cursors
  assign addr_x = (mode_q == M_SCAN) ? ex_q : px_q;
  assign addr_y = (mode_q == M_SCAN) ? ey_q : py_q;
  assign addr_a = desc_q ? addr_y : addr_x;
  assign addr_b = desc_q ? addr_x : addr_y;

  nosc_ram #(.Width(UnitW), .Depth(MAX_LEN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (load_count_q[AW-1:0]),
    .wdata_i (in_i.char_a),
    .raddr_i (addr_a[AW-1:0]),
    .rdata_o (rd_a)
  );

  nosc_ram #(.Width(UnitW), .Depth(MAX_LEN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (load_count_q[AW-1:0]),
    .wdata_i (in_i.char_b),
    .raddr_i (addr_b[AW-1:0]),
    .rdata_o (rd_b)
  );

  // Positions at or beyond the loaded length read as end of string
  assign dx = ok_x_q ? (desc_q ? rd_b : rd_a) : '0;
  assign dy = ok_y_q ? (desc_q ? rd_a : rd_b) : '0;

  assign lx = ex_q - px_q;
  assign ly = ey_q - py_q;
  assign ovf_new = ovf_q || (!buf_free && ((in_i.char_a != '0) || (in_i.char_b != '0)));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    load_count_d = load_count_q;
    ovf_d        = ovf_q;
    desc_d       = desc_q;
    px_d         = px_q;
    py_d         = py_q;
    ex_d         = ex_q;
    ey_d         = ey_q;
    xdone_d      = xdone_q;
    ydone_d      = ydone_q;
    verdict_d    = verdict_q;
    trunc_d      = trunc_q;
    out_valid_d  = out_valid_q;
    out_order_d  = out_order_q;
    out_trunc_d  = out_trunc_q;
    we           = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (buf_free) begin
            we           = 1'b1;
            load_count_d = load_count_q + CW'(1);
          end
          ovf_d = ovf_new;
          if (in_i.last) begin
            trunc_d = ovf_new;
            ovf_d   = 1'b0;
            desc_d  = desc_cfg_q;
            px_d    = '0;
            py_d    = '0;
            mode_d  = M_CHAR;
            state_d = ST_FETCH;
          end
        end
      end

      ST_FETCH: begin
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        state_d = ST_FETCH;
        case (mode_q)
          // Plain characters and string ends
          M_CHAR: begin
            if ((dx == '0) && (dy == '0)) begin
              verdict_d = ORDER_EQUAL;
              state_d   = ST_DONE;
            end else if (dx == '0) begin
              verdict_d = ORDER_LESS;
              state_d   = ST_DONE;
            end else if (dy == '0) begin
              verdict_d = ORDER_GREATER;
              state_d   = ST_DONE;
            end else if (is_digit(dx) && is_digit(dy)) begin
              ex_d    = px_q + CW'(1);
              ey_d    = py_q + CW'(1);
              xdone_d = 1'b0;
              ydone_d = 1'b0;
              mode_d  = M_SCAN;
            end else if (fold_case(dx) != fold_case(dy)) begin
              verdict_d = (fold_case(dx) < fold_case(dy)) ? ORDER_LESS : ORDER_GREATER;
              state_d   = ST_DONE;
            end else begin
              px_d = px_q + CW'(1);
              py_d = py_q + CW'(1);
            end
          end

          // Find the end of both digit runs in parallel
          M_SCAN: begin
            if (!xdone_q) begin
              if (is_digit(dx)) ex_d = ex_q + CW'(1);
              else              xdone_d = 1'b1;
            end
            if (!ydone_q) begin
              if (is_digit(dy)) ey_d = ey_q + CW'(1);
              else              ydone_d = 1'b1;
            end
            if (xdone_d && ydone_d) begin
              mode_d = M_RUN;
            end
          end

          // Drop leading zeros of the longer run, then compare digit by digit
          M_RUN: begin
            if (lx > ly) begin
              if (dx == DIGIT_ZERO) begin
                px_d = px_q + CW'(1);
              end else begin
                verdict_d = ORDER_GREATER;
                state_d   = ST_DONE;
              end
            end else if (lx < ly) begin
              if (dy == DIGIT_ZERO) begin
                py_d = py_q + CW'(1);
              end else begin
                verdict_d = ORDER_LESS;
                state_d   = ST_DONE;
              end
            end else if (px_q == ex_q) begin
              mode_d = M_CHAR;
            end else if (dx != dy) begin
              verdict_d = (dx < dy) ? ORDER_LESS : ORDER_GREATER;
              state_d   = ST_DONE;
            end else begin
              px_d = px_q + CW'(1);
              py_d = py_q + CW'(1);
            end
          end

          default: begin
            mode_d = M_CHAR;
          end
        endcase
      end

      // Hand the verdict to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_order_d  = verdict_q;
          out_trunc_d  = trunc_q;
          load_count_d = '0;
          state_d      = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      mode_q       <= M_CHAR;
      load_count_q <= '0;
      ovf_q        <= 1'b0;
      desc_cfg_q   <= 1'b0;
      desc_q       <= 1'b0;
      px_q         <= '0;
      py_q         <= '0;
      ex_q         <= '0;
      ey_q         <= '0;
      xdone_q      <= 1'b0;
      ydone_q      <= 1'b0;
      ok_x_q       <= 1'b0;
      ok_y_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      load_count_q <= load_count_d;
      ovf_q        <= ovf_d;
      if (cfg_we_i) begin
        desc_cfg_q <= cfg_wdata_i;
      end
      desc_q       <= desc_d;
      px_q         <= px_d;
      py_q         <= py_d;
      ex_q         <= ex_d;
      ey_q         <= ey_d;
      xdone_q      <= xdone_d;
      ydone_q      <= ydone_d;
      ok_x_q       <= addr_x < load_count_q;
      ok_y_q       <= addr_y < load_count_q;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    verdict_q   <= verdict_d;
    trunc_q     <= trunc_d;
    out_order_q <= out_order_d;
    out_trunc_q <= out_trunc_d;
  end

  // Assertions
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q <= CW'(MAX_LEN))
    else $error("load count beyond buffer depth");

  a_last_starts_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last |=> state_q == ST_FETCH)
    else $error("last request did not start the walk");

  a_run_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) && (mode_q == M_RUN) |-> (px_q <= ex_q) && (py_q <= ey_q))
    else $error("run cursor passed run end");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_SCAN) && (state_q == ST_FETCH) |->
      (ex_q <= load_count_q) && (ey_q <= load_count_q))
    else $error("run scan beyond loaded length");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("verdict appeared without a finished walk");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the natural-order string comparator. Character-pair requests
// are fed from a queue through a bursty driver; a behavioural model predicts
// each verdict as requests are accepted, and a monitor compares the verdict
// channel against it field by field. The run covers both sort directions,
// digit runs with leading zeros, case folding, raw 16-bit units, buffer
// overflow and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import nosc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen       = 64;
  localparam int SettleCycles = 6 * MaxLen + 20;
  localparam int HoldCycles   = 400;
  localparam int IdleLimit    = 5000;

  typedef struct packed {
    logic [UnitW-1:0] char_a;
    logic [UnitW-1:0] char_b;
    logic             last;
  } pair_req_t;

  typedef struct packed {
    logic [OrderW-1:0] order;
    logic              truncated;
  } verdict_t;

  typedef logic [UnitW-1:0] unit_q_t[$];

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  nosc_in_if  req_if ();
  nosc_out_if verdict_if ();

  natural_order_string_compare #(
    .MAX_LEN(MaxLen)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (verdict_if)
  );

  // Pending requests, and verdicts still owed by the block
  pair_req_t pending_reqs[$];
  verdict_t  expected_verdicts[$];

  // Model copy of the buffers and configuration
  logic [UnitW-1:0] stored_a[MaxLen];
  logic [UnitW-1:0] stored_b[MaxLen];
  int               stored_len;
  bit               overflow_seen;
  bit               descending_cfg;

  // Control between the stimulus thread and the clocked processes
  bit steady_send;
  int hold_requests;

  // Bookkeeping
  int pairs_queued;
  int pairs_sent;
  int verdicts_seen;
  int truncated_seen;
  int verdict_tally[3];
  int mismatches;

  logic [UnitW-1:0] punct_units[10] = '{16'h0020, 16'h002D, 16'h005F, 16'h002E,
                                         16'h0040, 16'h005B, 16'h0060, 16'h007B,
                                         16'h002F, 16'h003A};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Anything at or past the loaded length reads as end of string
  function automatic logic [UnitW-1:0] stored_unit(bit side_b, int pos);
    if (pos >= stored_len) return '0;
    return side_b ? stored_b[pos] : stored_a[pos];
  endfunction

  function automatic bit is_numeral(logic [UnitW-1:0] c);
    return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
  endfunction

  function automatic logic [UnitW-1:0] lower_ascii(logic [UnitW-1:0] c);
    if ((c >= UPPER_A) && (c <= UPPER_Z)) return c | CASE_OFFSET;
    return c;
  endfunction

  // Natural-order walk; swap picks text b as the left-hand string
  function automatic int natural_walk(bit swap);
    int px, py, ex, ey, k;
    logic [UnitW-1:0] cx, cy, dx, dy;
    px = 0;
    py = 0;
    while (1) begin
      cx = stored_unit(swap, px);
      cy = stored_unit(!swap, py);
      if (cx == '0 && cy == '0) return 0;
      if (cx == '0) return -1;
      if (cy == '0) return 1;
      if (is_numeral(cx) && is_numeral(cy)) begin
        ex = px + 1;
        ey = py + 1;
        while (is_numeral(stored_unit(swap, ex))) ex++;
        while (is_numeral(stored_unit(!swap, ey))) ey++;
        // strip leading zeros off the longer run until the lengths agree
        while ((ex - px) != (ey - py)) begin
          if ((ex - px) > (ey - py)) begin
            if (stored_unit(swap, px) != DIGIT_ZERO) return 1;
            px++;
          end else begin
            if (stored_unit(!swap, py) != DIGIT_ZERO) return -1;
            py++;
          end
        end
        for (k = 0; k < ex - px; k++) begin
          dx = stored_unit(swap, px + k);
          dy = stored_unit(!swap, py + k);
          if (dx != dy) return (dx < dy) ? -1 : 1;
        end
        px = ex;
        py = ey;
      end else begin
        cx = lower_ascii(cx);
        cy = lower_ascii(cy);
        if (cx != cy) return (cx < cy) ? -1 : 1;
        px++;
        py++;
      end
    end
    return 0;
  endfunction

  // Store one accepted request; on the final one, queue the verdict
  task automatic record_request(pair_req_t req);
    verdict_t v;
    int       r;
    if (stored_len < MaxLen) begin
      stored_a[stored_len] = req.char_a;
      stored_b[stored_len] = req.char_b;
      stored_len++;
    end else if (req.char_a != '0 || req.char_b != '0) begin
      overflow_seen = 1'b1;
    end
    if (req.last) begin
      r = natural_walk(descending_cfg);
      v.order     = (r < 0) ? ORDER_LESS : ((r == 0) ? ORDER_EQUAL : ORDER_GREATER);
      v.truncated = overflow_seen;
      expected_verdicts.push_back(v);
      stored_len    = 0;
      overflow_seen = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    int burst_left;
    int gap_left;
    bit offering;
    bit refill;
    if (!rst_ni) begin
      req_if.valid  <= 1'b0;
      req_if.char_a <= '0;
      req_if.char_b <= '0;
      req_if.last   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offering = req_if.valid;
      refill   = 1'b0;
      if (req_if.valid && req_if.ready) begin
        record_request(pending_reqs.pop_front());
        pairs_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          offering = 1'b1;
          refill   = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0 && !steady_send) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      req_if.valid <= offering;
      if (refill) begin
        req_if.char_a <= pending_reqs[0].char_a;
        req_if.char_b <= pending_reqs[0].char_b;
        req_if.last   <= pending_reqs[0].last;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Verdict receiver: stall pattern redrawn at random over the run, plus a
  // long hold-off when the stimulus thread asks for one
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    int       hold_left;
    int       holds_served;
    int       mode_left;
    int       tick;
    rx_mode_e rx_mode;
    bit       take;
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
      hold_left    = 0;
      holds_served = 0;
      mode_left    = 0;
      tick         = 0;
      rx_mode      = RX_ALWAYS;
    end else begin
      take = 1'b1;
      tick++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS: take = 1'b1;
          RX_COIN:   take = 1'($urandom_range(0, 1));
          RX_SPARSE: take = ($urandom_range(0, 3) == 0);
          default:   take = (tick % 3) != 0;
        endcase
      end
      verdict_if.ready <= take;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_verdicts
    verdict_t want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      verdicts_seen++;
      if (verdict_if.order < 3) verdict_tally[verdict_if.order]++;
      if (verdict_if.truncated) truncated_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected verdict %0d: order %0d truncated %0d at %0t",
                   verdicts_seen, verdict_if.order, verdict_if.truncated, $realtime);
        end
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_if.order !== want.order || verdict_if.truncated !== want.truncated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: verdict %0d: expected order %0d truncated %0d, got %0d %0d",
                     verdicts_seen, want.order, want.truncated,
                     verdict_if.order, verdict_if.truncated);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with work outstanding but no handshake on either side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((req_if.valid && req_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
      idle_cycles = 0;
    end else if (pending_reqs.size() != 0 || expected_verdicts.size() != 0 || req_if.valid) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no progress for %0d cycles, %0d verdicts outstanding",
                 idle_cycles, expected_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [UnitW-1:0] any_unit();
    return UnitW'($urandom_range(1, 65535));
  endfunction

  // Unit at position pos of a string: its text, one terminator, then padding
  function automatic logic [UnitW-1:0] fill_unit(unit_q_t s, int pos, bit junk);
    if (pos < s.size()) return s[pos];
    if (pos == s.size() || !junk) return '0;
    return UnitW'($urandom_range(0, 65535));
  endfunction

  task automatic enqueue_pair(unit_q_t a, unit_q_t b, int pad, bit junk);
    pair_req_t req;
    int        n;
    int        i;
    n = ((a.size() > b.size()) ? a.size() : b.size()) + pad;
    if (n == 0) n = 1;
    for (i = 0; i < n; i++) begin
      req.char_a = fill_unit(a, i, junk);
      req.char_b = fill_unit(b, i, junk);
      req.last   = (i == n - 1);
      pending_reqs.push_back(req);
      pairs_queued++;
    end
  endtask

  task automatic add_token(ref unit_q_t s);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // digit run, now and then with leading zeros
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) s.push_back(DIGIT_ZERO);
        repeat ($urandom_range(1, 5)) s.push_back(DIGIT_ZERO + UnitW'($urandom_range(0, 9)));
      end
      4, 5, 6: begin
        repeat ($urandom_range(1, 3)) begin
          s.push_back(($urandom_range(0, 1) ? UPPER_A : (UPPER_A | CASE_OFFSET))
                      + UnitW'($urandom_range(0, 25)));
        end
      end
      7, 8:    s.push_back(punct_units[$urandom_range(0, 9)]);
      default: s.push_back(any_unit());
    endcase
  endtask

  task automatic build_text(ref unit_q_t s, input int tokens);
    repeat (tokens) add_token(s);
  endtask

  // Small edits so that the pair agrees far into the walk
  task automatic mutate(ref unit_q_t s);
    int i;
    repeat ($urandom_range(1, 2)) begin
      i = (s.size() == 0) ? 0 : $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 6))
        0: if (s.size() != 0 && lower_ascii(s[i]) != s[i]) s[i] = s[i] | CASE_OFFSET;
           else if (s.size() != 0 && s[i] >= 16'h0061 && s[i] <= 16'h007A)
             s[i] = s[i] ^ CASE_OFFSET;
        1: if (s.size() != 0 && is_numeral(s[i]))
             s[i] = DIGIT_ZERO + UnitW'($urandom_range(0, 9));
        2: s.insert(i, DIGIT_ZERO);
        3: if (s.size() != 0) s.delete(i);
        4: add_token(s);
        5: if (s.size() != 0) s[i] = any_unit();
        default: while (s.size() > i) void'(s.pop_back());
      endcase
    end
  endtask

  task automatic directed_pair(string ta, string tb, int pad);
    unit_q_t a;
    unit_q_t b;
    foreach (ta[i]) a.push_back({8'h00, ta[i]});
    foreach (tb[i]) b.push_back({8'h00, tb[i]});
    enqueue_pair(a, b, pad, 1'b0);
  endtask

  // Buffer-length cases: full-length digit runs, overflow with and without
  // nonzero units past the end
  task automatic long_checks();
    unit_q_t a;
    unit_q_t b;
    repeat (MaxLen) a.push_back(DIGIT_ZERO + UnitW'(1));
    b = a;
    b[MaxLen - 1] = DIGIT_ZERO + UnitW'(2);
    enqueue_pair(a, b, 0, 1'b0);
    a.delete();
    repeat (MaxLen + 6) a.push_back(16'h0071);
    enqueue_pair(a, a, 0, 1'b0);
    a.delete();
    b.delete();
    build_text(a, 3);
    b = a;
    mutate(b);
    enqueue_pair(a, b, MaxLen + 4, 1'b0);
    enqueue_pair(b, a, MaxLen + 4, 1'b1);
  endtask

  task automatic random_pairs(int target);
    unit_q_t a;
    unit_q_t b;
    int      start;
    start = pairs_queued;
    while (pairs_queued - start < target) begin
      a.delete();
      b.delete();
      case ($urandom_range(0, 39))
        0: begin
          // long pair that may run past the buffer
          build_text(a, $urandom_range(20, 40));
          b = a;
          mutate(b);
          enqueue_pair(a, b, $urandom_range(0, 10), 1'($urandom_range(0, 1)));
        end
        1, 2, 3: begin
          // raw units, zeros included anywhere
          repeat ($urandom_range(1, 4)) begin
            a.push_back(UnitW'($urandom_range(0, 65535)));
            b.push_back(UnitW'($urandom_range(0, 65535)));
          end
          enqueue_pair(a, b, 0, 1'b0);
        end
        4, 5, 6, 7, 8, 9: begin
          build_text(a, $urandom_range(0, 4));
          build_text(b, $urandom_range(0, 4));
          enqueue_pair(a, b, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
        end
        default: begin
          build_text(a, $urandom_range(1, 5));
          b = a;
          if ($urandom_range(0, 4) != 0) mutate(b);
          if ($urandom_range(0, 1)) begin
            enqueue_pair(a, b, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
          end else begin
            enqueue_pair(b, a, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
          end
        end
      endcase
    end
  endtask

  task automatic set_descending(bit value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    descending_cfg = value;
  endtask

  // Hold the sender until every verdict is back, then let the walk settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_verdicts.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    req_if.valid     = 1'b0;
    req_if.char_a    = '0;
    req_if.char_b    = '0;
    req_if.last      = 1'b0;
    verdict_if.ready = 1'b0;
    steady_send      = 1'b0;
    hold_requests    = 0;
    stored_len       = 0;
    overflow_seen    = 1'b0;
    descending_cfg   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ends, case folding, digit runs, raw extremes
    set_descending(1'b0);
    @(negedge clk_i);
    directed_pair("", "", 0);
    directed_pair("a", "B", 0);
    directed_pair("Zeta", "zeta", 1);
    directed_pair("x9", "x10", 0);
    directed_pair("007", "7", 1);
    directed_pair("a12", "a13", 0);
    directed_pair("ab", "abc", 1);
    directed_pair("5", "a", 0);
    directed_pair("_", "A", 0);
    directed_pair("10", "9", 0);
    pending_reqs.push_back('{char_a: 16'hFFFF, char_b: 16'h0001, last: 1'b1});
    pairs_queued++;
    wait_idle();

    // Descending, with the buffer-length cases up front
    set_descending(1'b1);
    @(negedge clk_i);
    long_checks();
    random_pairs(300);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering
    set_descending(1'b0);
    @(negedge clk_i);
    steady_send = 1'b1;
    hold_requests++;
    random_pairs(150);
    wait_idle();
    steady_send = 1'b0;

    @(negedge clk_i);
    random_pairs(380);
    wait_idle();

    set_descending(1'b1);
    @(negedge clk_i);
    random_pairs(380);
    wait_idle();

    $display("Covered %0d pair requests, %0d verdicts (less %0d, equal %0d, greater %0d)",
             pairs_sent, verdicts_seen, verdict_tally[0], verdict_tally[1], verdict_tally[2]);
    $display("Truncated verdicts %0d, both sort directions, mismatches %0d",
             truncated_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/nosc_pkg.sv
rtl/nosc_if.sv
rtl/nosc_ram.sv
rtl/natural_order_string_compare.sv
verif/tb_top.sv
